// File: rtl/core/csu_pkg.sv
// csu_pkg: shared types and constants of the counting semaphore unit
// opcode and status codes, fixed field widths and value limits
// no dependencies
package csu_pkg;

    localparam int OPCODE_W  = 2;
    localparam int SEM_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int VALUE_W   = 8;

    typedef logic [OPCODE_W-1:0]       t_opcode;
    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_opcode OP_CREATE = 2'd0;
    localparam t_opcode OP_WAIT   = 2'd1;
    localparam t_opcode OP_SIGNAL = 2'd2;

    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_EXISTS      = 2'd1;
    localparam t_status ST_NOT_CREATED = 2'd2;
    localparam t_status ST_QUEUE_FULL  = 2'd3;

    localparam t_value VALUE_MAX   = 8'sd127;
    localparam t_value VALUE_MIN   = -8'sd128;
    localparam t_value VALUE_RESET = 8'sd1;

endpackage

// File: rtl/core/csu_ram.sv
// csu_ram: generic single-write, single-read ram with registered read data
// no dependencies; contents are undefined until written
module csu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/counting_semaphore_unit.sv
// counting_semaphore_unit: bank of counting semaphores with fifo wait queues
// an accepted word is held in the input stage, its result in the result register
// throughput: one word per cycle unless the result stalls; the wait-queue ram read
// is issued at accept, the state read-modify-write as the word leaves the input stage
// reset: i_rst_n synchronous active low; no word taken while held; all semaphores
// uncreated, value 1, queues empty; the wait-queue ram itself is not cleared
module counting_semaphore_unit #(
    parameter int NUM_SEMS    = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_WIDTH   = 8,
    localparam int IN_BITS    = csu_pkg::OPCODE_W + csu_pkg::SEM_IDX_W + PID_WIDTH + 1,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = csu_pkg::STATUS_W + csu_pkg::VALUE_W + 3 + PID_WIDTH,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // opcode, sem_index, caller_pid, caller_is_init
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // status, new_value, caller_blocked, woke_one, woken_pid, reschedule
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int SEM_IW    = NUM_SEMS > 1 ? $clog2(NUM_SEMS) : 1;
    localparam int SW        = SEM_IW > csu_pkg::SEM_IDX_W ? SEM_IW : csu_pkg::SEM_IDX_W;
    localparam int QW        = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH > 1 ? RAM_DEPTH : 2);
    localparam int P_LO      = csu_pkg::OPCODE_W + csu_pkg::SEM_IDX_W;

    // input unpack
    csu_pkg::t_opcode              in_op;
    logic [csu_pkg::SEM_IDX_W-1:0] in_sem;
    logic [PID_WIDTH-1:0]          in_pid;
    logic                          in_init;
    logic [SW-1:0]                 in_sem_x;
    logic                          in_rng;
    logic [SEM_IW-1:0]             in_sidx;

    assign in_op    = i_s_tdata[csu_pkg::OPCODE_W-1:0];
    assign in_sem   = i_s_tdata[csu_pkg::OPCODE_W +: csu_pkg::SEM_IDX_W];
    assign in_pid   = i_s_tdata[P_LO +: PID_WIDTH];
    assign in_init  = i_s_tdata[P_LO + PID_WIDTH];
    assign in_sem_x = SW'(in_sem);
    assign in_rng   = ({1'b0, in_sem_x} < (SW + 1)'(NUM_SEMS));
    assign in_sidx  = in_sem_x[SEM_IW-1:0];

    // input stage
    logic                          r_v1;
    csu_pkg::t_opcode              r_op;
    logic [csu_pkg::SEM_IDX_W-1:0] r_sem;
    logic [PID_WIDTH-1:0]          r_pid;
    logic                          r_init;
    logic                          r_byp;
    logic [PID_WIDTH-1:0]          r_byp_data;

    // semaphore state
    logic                  r_created [NUM_SEMS];
    csu_pkg::t_value       r_val     [NUM_SEMS];
    logic [QW-1:0]         r_head    [NUM_SEMS];
    logic [QW-1:0]         r_tail    [NUM_SEMS];
    logic [CW-1:0]         r_cnt     [NUM_SEMS];

    // result register
    logic             r_ov;
    logic [OUT_W-1:0] r_odata;

    logic accept;
    logic adv;

    assign adv        = r_v1 && (!r_ov || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_v1 || adv);
    assign accept     = i_s_tvalid && o_s_tready;

    // processing of the word in the input stage
    logic [SW-1:0]        sem_x;
    logic                 rng;
    logic [SEM_IW-1:0]    sidx;
    logic                 cur_created;
    csu_pkg::t_value      cur_v;
    logic [QW-1:0]        cur_head;
    logic [QW-1:0]        cur_tail;
    logic [CW-1:0]        cur_cnt;
    logic [QW-1:0]        head_inc;
    logic [QW-1:0]        tail_inc;
    csu_pkg::t_value      dec_v;
    csu_pkg::t_value      inc_v;
    logic [PID_WIDTH-1:0] ram_q;
    logic [PID_WIDTH-1:0] ram_rdata;

    csu_pkg::t_status     st;
    csu_pkg::t_value      nv;
    logic                 blk;
    logic                 woke;
    logic [PID_WIDTH-1:0] wpid;
    logic                 resch;
    logic                 do_create;
    logic                 do_setv;
    logic                 do_push;
    logic                 do_pop;
    logic [OUT_W-1:0]     n_odata;

    assign sem_x       = SW'(r_sem);
    assign rng         = ({1'b0, sem_x} < (SW + 1)'(NUM_SEMS));
    assign sidx        = sem_x[SEM_IW-1:0];
    assign cur_created = rng ? r_created[sidx] : 1'b0;
    assign cur_v       = rng ? r_val[sidx] : csu_pkg::VALUE_RESET;
    assign cur_head    = rng ? r_head[sidx] : '0;
    assign cur_tail    = rng ? r_tail[sidx] : '0;
    assign cur_cnt     = rng ? r_cnt[sidx] : '0;
    assign head_inc    = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + QW'(1);
    assign tail_inc    = (cur_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + QW'(1);
    assign dec_v       = (cur_v == csu_pkg::VALUE_MIN) ? csu_pkg::VALUE_MIN : cur_v - 8'sd1;
    assign inc_v       = (cur_v == csu_pkg::VALUE_MAX) ? csu_pkg::VALUE_MAX : cur_v + 8'sd1;
    assign ram_q       = r_byp ? r_byp_data : ram_rdata;

    always_comb begin
        st        = csu_pkg::ST_OK;
        nv        = cur_v;
        blk       = 1'b0;
        woke      = 1'b0;
        wpid      = '0;
        resch     = 1'b0;
        do_create = 1'b0;
        do_setv   = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        if (!rng) begin
            st = csu_pkg::ST_NOT_CREATED;
            nv = '0;
        end else begin
            case (r_op)
                csu_pkg::OP_CREATE: begin
                    if (cur_created) begin
                        st = csu_pkg::ST_EXISTS;
                    end else begin
                        do_create = 1'b1;
                    end
                end
                csu_pkg::OP_WAIT: begin
                    if (!cur_created) begin
                        st = csu_pkg::ST_NOT_CREATED;
                    end else if (dec_v < 0 && !r_init) begin
                        if (cur_cnt >= CW'(QUEUE_DEPTH)) begin
                            st = csu_pkg::ST_QUEUE_FULL;
                        end else begin
                            nv      = dec_v;
                            do_setv = 1'b1;
                            do_push = 1'b1;
                            blk     = 1'b1;
                            resch   = 1'b1;
                        end
                    end else begin
                        nv      = dec_v;
                        do_setv = 1'b1;
                    end
                end
                csu_pkg::OP_SIGNAL: begin
                    if (!cur_created) begin
                        st = csu_pkg::ST_NOT_CREATED;
                    end else begin
                        nv      = inc_v;
                        do_setv = 1'b1;
                        if (inc_v <= 0 && cur_cnt != '0) begin
                            do_pop = 1'b1;
                            woke   = 1'b1;
                            wpid   = ram_q;
                            resch  = r_init;
                        end
                    end
                end
                default: ;
            endcase
        end
        n_odata = '0;
        n_odata[OUT_BITS-1:0] = {resch, wpid, woke, blk, nv, st};
    end

    // wait-queue ram addressing with look-ahead of the head being popped
    function automatic logic [AW-1:0] q_addr(input logic [SEM_IW-1:0] s,
                                            input logic [QW-1:0] p);
        q_addr = AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
    endfunction

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [QW-1:0] rd_ptr;
    logic          byp_hit;

    always_comb begin
        if (adv && do_pop && sidx == in_sidx) begin
            rd_ptr = head_inc;
        end else if (in_rng) begin
            rd_ptr = r_head[in_sidx];
        end else begin
            rd_ptr = '0;
        end
    end

    assign ram_we    = adv && do_push;
    assign ram_waddr = q_addr(sidx, cur_tail);
    assign ram_raddr = q_addr(in_sidx, rd_ptr);
    assign byp_hit   = ram_we && (ram_waddr == ram_raddr);

    csu_ram #(
        .WIDTH (PID_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_pid),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // input stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_byp <= 1'b0;
        end else if (accept) begin
            r_v1  <= 1'b1;
            r_byp <= byp_hit;
        end else if (adv) begin
            r_v1  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= in_op;
            r_sem      <= in_sem;
            r_pid      <= in_pid;
            r_init     <= in_init;
            r_byp_data <= r_pid;
        end
    end

    // semaphore state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SEMS; i++) begin
                r_created[i] <= 1'b0;
                r_val[i]     <= csu_pkg::VALUE_RESET;
                r_head[i]    <= '0;
                r_tail[i]    <= '0;
                r_cnt[i]     <= '0;
            end
        end else if (adv) begin
            if (do_create) begin
                r_created[sidx] <= 1'b1;
            end
            if (do_setv) begin
                r_val[sidx] <= nv;
            end
            if (do_push) begin
                r_tail[sidx] <= tail_inc;
                r_cnt[sidx]  <= cur_cnt + CW'(1);
            end
            if (do_pop) begin
                r_head[sidx] <= head_inc;
                r_cnt[sidx]  <= cur_cnt - CW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= n_odata;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;

endmodule

// File: rtl/core/csu_checker.sv
// csu_checker: port-level checks of the counting semaphore unit
// depends on csu_pkg; bound to counting_semaphore_unit at the end of this file
module csu_checker #(
    parameter int PID_WIDTH = 8,
    localparam int OUT_BITS = csu_pkg::STATUS_W + csu_pkg::VALUE_W + 3 + PID_WIDTH,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    localparam int V_LO = csu_pkg::STATUS_W;
    localparam int B_AT = csu_pkg::STATUS_W + csu_pkg::VALUE_W;

    csu_pkg::t_status     st;
    logic                 neg;
    logic                 blk;
    logic                 woke;
    logic [PID_WIDTH-1:0] wpid;
    logic                 resch;

    assign st    = o_m_tdata[csu_pkg::STATUS_W-1:0];
    assign neg   = o_m_tdata[V_LO + csu_pkg::VALUE_W - 1];
    assign blk   = o_m_tdata[B_AT];
    assign woke  = o_m_tdata[B_AT + 1];
    assign wpid  = o_m_tdata[B_AT + 2 +: PID_WIDTH];
    assign resch = o_m_tdata[B_AT + 2 + PID_WIDTH];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // a failed call changes nothing and wakes or blocks nobody
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && st != csu_pkg::ST_OK |-> !blk && !woke && !resch && wpid == '0)
        else $error("error result with side effects");

    // a blocked caller leaves a negative value and asks for a reschedule
    a_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && blk |-> st == csu_pkg::ST_OK && neg && resch && !woke)
        else $error("inconsistent blocked result");

    // with nobody woken the woken id is zero and only a block reschedules
    a_no_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !woke |-> wpid == '0 && (resch == blk))
        else $error("woken id or reschedule without a wake");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind counting_semaphore_unit csu_checker #(
    .PID_WIDTH (PID_WIDTH)
) u_csu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: tb/sv/counting_semaphore_unit_tb.sv
// counting_semaphore_unit_tb: self-checking bench for the semaphore bank
// drives calls over the slave stream and checks every reply word against a table row or a predictor
// depends on csu_pkg and counting_semaphore_unit
module counting_semaphore_unit_tb;

    localparam int               SEMS        = 8;
    localparam int               WAIT_DEPTH  = 16;
    localparam int               HOLD_CYCLES = 300;
    localparam int               QUIET_LIMIT = 20000;
    localparam csu_pkg::t_opcode OP_NONE     = 2'd3;

    typedef struct {
        csu_pkg::t_status status;
        csu_pkg::t_value  level;
        logic             blocked;
        logic             woke;
        logic [7:0]       woken;
        logic             resched;
    } t_reply;

    typedef struct {
        csu_pkg::t_opcode op;
        logic [2:0]       sem;
        logic [7:0]       pid;
        logic             init;
        bit               fixed;
        t_reply           reply;
    } t_call_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // opcode, sem_index, caller_pid, caller_is_init
    logic [15:0] i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // status, new_value, caller_blocked, woke_one, woken_pid, reschedule
    logic [23:0] o_m_tdata;

    // predicted semaphore bank
    bit         sem_made [SEMS] = '{default: 1'b0};
    int         sem_level[SEMS] = '{default: 1};
    logic [7:0] waiter_ring[SEMS][WAIT_DEPTH];
    int         ring_head[SEMS] = '{default: 0};
    int         ring_fill[SEMS] = '{default: 0};

    t_reply replies_due[$];
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_tickets   = 0;
    int     errors         = 0;
    int     calls_sent     = 0;
    int     replies_seen   = 0;
    int     n_blocked      = 0;
    int     n_woken        = 0;
    int     n_refused      = 0;
    int     n_saturated    = 0;

    counting_semaphore_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_reply semaphore_call(csu_pkg::t_opcode op, logic [2:0] sem,
                                              logic [7:0] pid, logic init);
        t_reply r;
        int     lvl;
        int     nxt;
        r = '{default: '0};
        lvl = sem_level[sem];
        case (op)
            csu_pkg::OP_CREATE: begin
                if (sem_made[sem]) r.status = csu_pkg::ST_EXISTS;
                else sem_made[sem] = 1'b1;
            end
            csu_pkg::OP_WAIT, csu_pkg::OP_SIGNAL: begin
                if (!sem_made[sem]) begin
                    r.status = csu_pkg::ST_NOT_CREATED;
                end else if (op == csu_pkg::OP_WAIT) begin
                    nxt = (lvl > int'(csu_pkg::VALUE_MIN)) ? lvl - 1 : int'(csu_pkg::VALUE_MIN);
                    if (lvl == int'(csu_pkg::VALUE_MIN)) n_saturated++;
                    if (nxt < 0 && !init) begin
                        if (ring_fill[sem] >= WAIT_DEPTH) begin
                            r.status = csu_pkg::ST_QUEUE_FULL;
                            n_refused++;
                        end else begin
                            waiter_ring[sem][(ring_head[sem] + ring_fill[sem]) % WAIT_DEPTH] = pid;
                            ring_fill[sem]++;
                            lvl = nxt;
                            r.blocked = 1'b1;
                            r.resched = 1'b1;
                            n_blocked++;
                        end
                    end else begin
                        lvl = nxt;
                    end
                end else begin
                    if (lvl == int'(csu_pkg::VALUE_MAX)) n_saturated++;
                    lvl = (lvl < int'(csu_pkg::VALUE_MAX)) ? lvl + 1 : int'(csu_pkg::VALUE_MAX);
                    if (lvl <= 0 && ring_fill[sem] != 0) begin
                        r.woken = waiter_ring[sem][ring_head[sem]];
                        ring_head[sem] = (ring_head[sem] + 1) % WAIT_DEPTH;
                        ring_fill[sem]--;
                        r.woke = 1'b1;
                        r.resched = init;
                        n_woken++;
                    end
                end
                sem_level[sem] = lvl;
            end
            default: begin
            end
        endcase
        r.level = csu_pkg::t_value'(lvl);
        return r;
    endfunction

    task automatic issue_call(csu_pkg::t_opcode op, logic [2:0] sem, logic [7:0] pid,
                              logic init, bit fixed, t_reply fixed_reply);
        int     gap;
        t_reply want;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, init, pid, sem, op};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        want = semaphore_call(op, sem, pid, init);
        replies_due.push_back(fixed ? fixed_reply : want);
        calls_sent++;
    endtask

    // lower valid, then hold off until every reply is in
    task automatic wait_for_replies();
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (replies_due.size() != 0);
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_reply(logic [23:0] word);
        t_reply want;
        if (replies_due.size() == 0) begin
            $error("reply word %h with nothing outstanding", word);
            errors++;
        end else begin
            want = replies_due.pop_front();
            replies_seen++;
            compare_field("status", int'(want.status), int'(word[1:0]));
            compare_field("new_value", int'(want.level), int'($signed(word[9:2])));
            compare_field("caller_blocked", int'(want.blocked), int'(word[10]));
            compare_field("woke_one", int'(want.woke), int'(word[11]));
            compare_field("woken_pid", int'(want.woken), int'(word[19:12]));
            compare_field("reschedule", int'(want.resched), int'(word[20]));
        end
    endtask

    task automatic random_calls(int count);
        logic [2:0]       hot;
        logic [2:0]       sem;
        int               wait_pct;
        int               r;
        csu_pkg::t_opcode op;
        t_reply           none;
        none = '{default: '0};
        hot = 3'd0;
        wait_pct = 50;
        for (int i = 0; i < count; i++) begin
            // bursts on one semaphore, alternately draining and refilling it
            if (i % 50 == 0) begin
                hot = 3'($urandom_range(SEMS - 1));
                wait_pct = ((i / 50) % 2 == 0) ? 65 : 40;
            end
            sem = ($urandom_range(99) < 75) ? hot : 3'($urandom_range(SEMS - 1));
            r = $urandom_range(99);
            if (r < 3) op = csu_pkg::OP_CREATE;
            else if (r < 6) op = OP_NONE;
            else if (r < 6 + (94 * wait_pct) / 100) op = csu_pkg::OP_WAIT;
            else op = csu_pkg::OP_SIGNAL;
            issue_call(op, sem, 8'($urandom), $urandom_range(99) < 25, 1'b0, none);
        end
    endtask

    initial begin : reply_side
        int hold_left;
        int seen_tickets;
        hold_left = 0;
        seen_tickets = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) check_reply(o_m_tdata);
            if (hold_tickets != seen_tickets) begin
                seen_tickets = hold_tickets;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_call_row rows[22];
        t_reply    none;
        int        send_pcts[4];
        int        recv_pcts[4];
        none = '{default: '0};
        send_pcts = '{0, 55, 0, 30};
        recv_pcts = '{0, 0, 55, 30};
        rows = '{
            '{csu_pkg::OP_WAIT, 3'd0, 8'h00, 1'b0, 1'b1,
              '{csu_pkg::ST_NOT_CREATED, 8'sd1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_SIGNAL, 3'd7, 8'hff, 1'b1, 1'b1,
              '{csu_pkg::ST_NOT_CREATED, 8'sd1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{OP_NONE, 3'd3, 8'haa, 1'b0, 1'b1,
              '{csu_pkg::ST_OK, 8'sd1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_CREATE, 3'd0, 8'h00, 1'b0, 1'b1,
              '{csu_pkg::ST_OK, 8'sd1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_CREATE, 3'd0, 8'h01, 1'b1, 1'b1,
              '{csu_pkg::ST_EXISTS, 8'sd1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_CREATE, 3'd7, 8'hff, 1'b1, 1'b1,
              '{csu_pkg::ST_OK, 8'sd1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_WAIT, 3'd0, 8'h11, 1'b0, 1'b1,
              '{csu_pkg::ST_OK, 8'sd0, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_WAIT, 3'd0, 8'h22, 1'b0, 1'b1,
              '{csu_pkg::ST_OK, -8'sd1, 1'b1, 1'b0, 8'h00, 1'b1}},
            '{csu_pkg::OP_WAIT, 3'd0, 8'h33, 1'b1, 1'b1,
              '{csu_pkg::ST_OK, -8'sd2, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_SIGNAL, 3'd0, 8'h44, 1'b0, 1'b1,
              '{csu_pkg::ST_OK, -8'sd1, 1'b0, 1'b1, 8'h22, 1'b0}},
            '{csu_pkg::OP_SIGNAL, 3'd0, 8'h55, 1'b1, 1'b1,
              '{csu_pkg::ST_OK, 8'sd0, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_WAIT, 3'd0, 8'h66, 1'b0, 1'b1,
              '{csu_pkg::ST_OK, -8'sd1, 1'b1, 1'b0, 8'h00, 1'b1}},
            '{csu_pkg::OP_SIGNAL, 3'd0, 8'h01, 1'b1, 1'b1,
              '{csu_pkg::ST_OK, 8'sd0, 1'b0, 1'b1, 8'h66, 1'b1}},
            '{OP_NONE, 3'd0, 8'h5a, 1'b1, 1'b1,
              '{csu_pkg::ST_OK, 8'sd0, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{csu_pkg::OP_WAIT,   3'd7, 8'h80, 1'b0, 1'b0, none},
            '{csu_pkg::OP_CREATE, 3'd1, 8'h12, 1'b0, 1'b0, none},
            '{csu_pkg::OP_CREATE, 3'd2, 8'h34, 1'b1, 1'b0, none},
            '{csu_pkg::OP_CREATE, 3'd3, 8'h56, 1'b0, 1'b0, none},
            '{csu_pkg::OP_CREATE, 3'd4, 8'h78, 1'b1, 1'b0, none},
            '{csu_pkg::OP_CREATE, 3'd5, 8'h9a, 1'b0, 1'b0, none},
            '{csu_pkg::OP_CREATE, 3'd6, 8'hbc, 1'b1, 1'b0, none},
            '{csu_pkg::OP_SIGNAL, 3'd3, 8'h0f, 1'b0, 1'b0, none}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            issue_call(rows[i].op, rows[i].sem, rows[i].pid, rows[i].init, rows[i].fixed,
                       rows[i].reply);

        // semaphore 7 at zero: fill its wait queue, overflow it, wake everyone,
        // run it down to the floor and back up past the ceiling
        for (int i = 0; i < WAIT_DEPTH + 1; i++)
            issue_call(csu_pkg::OP_WAIT, 3'd7, 8'($urandom), 1'b0, 1'b0, none);
        for (int i = 0; i < WAIT_DEPTH; i++)
            issue_call(csu_pkg::OP_SIGNAL, 3'd7, 8'($urandom), 1'($urandom), 1'b0, none);
        for (int i = 0; i < 130; i++)
            issue_call(csu_pkg::OP_WAIT, 3'd7, 8'($urandom), 1'b1, 1'b0, none);
        issue_call(csu_pkg::OP_WAIT, 3'd7, 8'($urandom), 1'b0, 1'b0, none);
        for (int i = 0; i < 260; i++)
            issue_call(csu_pkg::OP_SIGNAL, 3'd7, 8'($urandom), 1'($urandom), 1'b0, none);
        wait_for_replies();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            random_calls(200);
            hold_tickets <= hold_tickets + 1;
            random_calls(200);
            wait_for_replies();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d calls sent and %0d reply words checked under four handshake mixes",
                 calls_sent, replies_seen);
        $display("%0d callers blocked, %0d woken, %0d refused on a full queue, %0d saturating",
                 n_blocked, n_woken, n_refused, n_saturated);
        if (errors == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
